>>> rtl/core/bis_pkg.sv
package bis_pkg;

  // Source store geometry
  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int COL_W          = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W          = $clog2(MAX_SRC_HEIGHT);
  localparam int NUM_BANKS      = 4;
  localparam int BANK_SEL_W     = 2;
  localparam int BANK_AW        = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_DEPTH     = (MAX_SRC_WIDTH / 2) * (MAX_SRC_HEIGHT / 2);

  // Field widths
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int PIX_W       = NUM_CH * CH_W;
  localparam int DST_W       = 12;
  localparam int SIZE_W      = 9;
  localparam int STEP_W      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 48;

  // Arithmetic
  localparam int STEP_FRAC_BITS   = 16;
  localparam int WEIGHT_FRAC_BITS = 8;
  localparam int POS_W   = DST_W + STEP_W;
  localparam int IPOS_W  = POS_W - STEP_FRAC_BITS;
  localparam int WONE_W  = WEIGHT_FRAC_BITS + 1;
  localparam int WGT_W   = 2 * WONE_W;
  localparam int PROD_W  = WGT_W + CH_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int RES_W   = SUM_W - 2 * WEIGHT_FRAC_BITS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd3;

  typedef logic [CH_W-1:0] chan_t;

  // Clamp a size to [2, maxv] and return size - 2, the largest base index.
  function automatic logic [SIZE_W-1:0] size_limit(input logic [SIZE_W-1:0] s,
                                                    input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] c;
    c = s;
    if (s < SIZE_W'(2)) c = SIZE_W'(2);
    else if (s > maxv) c = maxv;
    return c - SIZE_W'(2);
  endfunction

endpackage

>>> rtl/core/bilinear_image_scaler_unit.sv
// Bilinear image scaler. The source frame (RGB888, up to 256x256) lives in four
// synchronous RAM banks split by row and column parity, so the four neighbors of
// any query sit in four different banks and are read in the same cycle. A beat with
// tuser = 0 stores one source pixel and gives no output beat; a beat with
// tuser = 1 asks for destination pixel (dst_col, dst_row) and gives one output
// beat. The block takes one beat per cycle, every cycle, as long as the output
// side is not stalled. A query beat passes through the stage 1 register, the
// bank read together with the blend weights, the weight products, and then the
// sum and round into the output register. A pixel write followed directly by a
// query that reads it is served correctly: both touch the banks from the same
// stage, in beat order.
// Configuration writes are taken at any time but are only meaningful while the
// block is idle. Reading a source pixel that was never written gives undefined
// color.
module bilinear_image_scaler_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // src_col[7:0], src_row[15:8], pix_red[23:16], pix_green[31:24],
  // pix_blue[39:32], dst_col[51:40], dst_row[63:52]
  input  logic [bis_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // mode[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_col[35:24], out_row[47:36]
  output logic [bis_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration: keep the base-index limits (clamped size minus two) and steps
  // ---------------------------------------------------------------------------
  logic [bis_pkg::COL_W-1:0]  x_lim;
  logic [bis_pkg::ROW_W-1:0]  y_lim;
  logic [bis_pkg::STEP_W-1:0] x_step;
  logic [bis_pkg::STEP_W-1:0] y_step;
  logic [bis_pkg::SIZE_W-1:0] x_lim_next;
  logic [bis_pkg::SIZE_W-1:0] y_lim_next;

  assign x_lim_next = bis_pkg::size_limit(cfg_data[bis_pkg::SIZE_W-1:0],
                                          bis_pkg::SIZE_W'(bis_pkg::MAX_SRC_WIDTH));
  assign y_lim_next = bis_pkg::size_limit(cfg_data[bis_pkg::SIZE_W-1:0],
                                          bis_pkg::SIZE_W'(bis_pkg::MAX_SRC_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      x_lim  <= bis_pkg::COL_W'(bis_pkg::MAX_SRC_WIDTH - 2);
      y_lim  <= bis_pkg::ROW_W'(bis_pkg::MAX_SRC_HEIGHT - 2);
      x_step <= bis_pkg::STEP_W'(1 << bis_pkg::STEP_FRAC_BITS);
      y_step <= bis_pkg::STEP_W'(1 << bis_pkg::STEP_FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_index)
        bis_pkg::REG_SRC_WIDTH:  x_lim  <= x_lim_next[bis_pkg::COL_W-1:0];
        bis_pkg::REG_SRC_HEIGHT: y_lim  <= y_lim_next[bis_pkg::ROW_W-1:0];
        bis_pkg::REG_X_STEP:     x_step <= cfg_data[bis_pkg::STEP_W-1:0];
        bis_pkg::REG_Y_STEP:     y_step <= cfg_data[bis_pkg::STEP_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register is free or
  // being drained; otherwise the whole pipe, including the RAM read data, holds.
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input beat fields
  logic [bis_pkg::COL_W-1:0] in_col;
  logic [bis_pkg::ROW_W-1:0] in_row;
  logic [bis_pkg::PIX_W-1:0] in_pix;
  logic [bis_pkg::DST_W-1:0] in_dc;
  logic [bis_pkg::DST_W-1:0] in_dr;
  logic [bis_pkg::POS_W-1:0] in_posx;
  logic [bis_pkg::POS_W-1:0] in_posy;

  assign in_col = s_axis_tdata[7:0];
  assign in_row = s_axis_tdata[15:8];
  // stored as red in the top byte, blue in the bottom byte
  assign in_pix = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
  assign in_dc  = s_axis_tdata[51:40];
  assign in_dr  = s_axis_tdata[63:52];

  // Source position in Q.16, 12 x 24 bit products
  assign in_posx = bis_pkg::POS_W'(in_dc) * bis_pkg::POS_W'(x_step);
  assign in_posy = bis_pkg::POS_W'(in_dr) * bis_pkg::POS_W'(y_step);

  // ---------------------------------------------------------------------------
  // Stage 1: registered beat and source position
  // ---------------------------------------------------------------------------
  logic                      s1_valid;
  logic                      s1_mode;
  logic [bis_pkg::COL_W-1:0] s1_col;
  logic [bis_pkg::ROW_W-1:0] s1_row;
  logic [bis_pkg::PIX_W-1:0] s1_pix;
  logic [bis_pkg::DST_W-1:0] s1_dc;
  logic [bis_pkg::DST_W-1:0] s1_dr;
  logic [bis_pkg::POS_W-1:0] s1_posx;
  logic [bis_pkg::POS_W-1:0] s1_posy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode <= s_axis_tuser;
      s1_col  <= in_col;
      s1_row  <= in_row;
      s1_pix  <= in_pix;
      s1_dc   <= in_dc;
      s1_dr   <= in_dr;
      s1_posx <= in_posx;
      s1_posy <= in_posy;
    end
  end

  // Integer part clamped to the base limit, top fraction bits as weights
  logic [bis_pkg::IPOS_W-1:0]           ipx;
  logic [bis_pkg::IPOS_W-1:0]           ipy;
  logic [bis_pkg::COL_W-1:0]            tx;
  logic [bis_pkg::ROW_W-1:0]            ty;
  logic [bis_pkg::COL_W-1:0]            tx1;
  logic [bis_pkg::ROW_W-1:0]            ty1;
  logic [bis_pkg::WEIGHT_FRAC_BITS-1:0] u;
  logic [bis_pkg::WEIGHT_FRAC_BITS-1:0] v;
  logic [bis_pkg::WONE_W-1:0]           um;
  logic [bis_pkg::WONE_W-1:0]           vm;

  assign ipx = s1_posx[bis_pkg::POS_W-1:bis_pkg::STEP_FRAC_BITS];
  assign ipy = s1_posy[bis_pkg::POS_W-1:bis_pkg::STEP_FRAC_BITS];
  assign tx  = (ipx >= bis_pkg::IPOS_W'(x_lim)) ? x_lim : ipx[bis_pkg::COL_W-1:0];
  assign ty  = (ipy >= bis_pkg::IPOS_W'(y_lim)) ? y_lim : ipy[bis_pkg::ROW_W-1:0];
  assign tx1 = tx + bis_pkg::COL_W'(1);
  assign ty1 = ty + bis_pkg::ROW_W'(1);
  assign u   = s1_posx[bis_pkg::STEP_FRAC_BITS-1 -: bis_pkg::WEIGHT_FRAC_BITS];
  assign v   = s1_posy[bis_pkg::STEP_FRAC_BITS-1 -: bis_pkg::WEIGHT_FRAC_BITS];
  assign um  = bis_pkg::WONE_W'(1 << bis_pkg::WEIGHT_FRAC_BITS) - bis_pkg::WONE_W'(u);
  assign vm  = bis_pkg::WONE_W'(1 << bis_pkg::WEIGHT_FRAC_BITS) - bis_pkg::WONE_W'(v);

  // Pixel write from the same stage as the query reads, so beat order is kept
  logic                           wr_en;
  logic [bis_pkg::BANK_SEL_W-1:0] wr_bank;
  logic [bis_pkg::BANK_AW-1:0]    wr_addr;

  assign wr_en   = s1_valid && !s1_mode && adv;
  assign wr_bank = {s1_row[0], s1_col[0]};
  assign wr_addr = {s1_row[bis_pkg::ROW_W-1:1], s1_col[bis_pkg::COL_W-1:1]};

  // ---------------------------------------------------------------------------
  // Frame store: bank index = {row parity, column parity}
  // ---------------------------------------------------------------------------
  logic [bis_pkg::PIX_W-1:0] bank_rdata [bis_pkg::NUM_BANKS];

  for (genvar b = 0; b < bis_pkg::NUM_BANKS; b++) begin : g_bank
    localparam logic ROW_PAR = 1'((b >> 1) & 1);
    localparam logic COL_PAR = 1'(b & 1);

    logic [bis_pkg::PIX_W-1:0]   mem [bis_pkg::BANK_DEPTH];
    logic [bis_pkg::PIX_W-1:0]   rdata;
    logic [bis_pkg::ROW_W-1:0]   rd_row;
    logic [bis_pkg::COL_W-1:0]   rd_col;
    logic [bis_pkg::BANK_AW-1:0] rd_addr;

    // pick whichever of the two neighbor rows/columns has this bank's parity
    assign rd_row  = (ty[0] == ROW_PAR) ? ty : ty1;
    assign rd_col  = (tx[0] == COL_PAR) ? tx : tx1;
    assign rd_addr = {rd_row[bis_pkg::ROW_W-1:1], rd_col[bis_pkg::COL_W-1:1]};

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == bis_pkg::BANK_SEL_W'(b))) begin
        mem[wr_addr] <= s1_pix;
      end
      if (adv) begin
        rdata <= mem[rd_addr];
      end
    end

    assign bank_rdata[b] = rdata;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: neighbor data from the banks, blend weights
  // weight index k: bit 1 = next row, bit 0 = next column
  // ---------------------------------------------------------------------------
  logic                      s2_valid;
  logic                      s2_tx0;
  logic                      s2_ty0;
  logic [bis_pkg::WGT_W-1:0] s2_w [4];
  logic [bis_pkg::DST_W-1:0] s2_dc;
  logic [bis_pkg::DST_W-1:0] s2_dr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tx0  <= tx[0];
      s2_ty0  <= ty[0];
      s2_w[0] <= bis_pkg::WGT_W'(um) * bis_pkg::WGT_W'(vm);
      s2_w[1] <= bis_pkg::WGT_W'(u) * bis_pkg::WGT_W'(vm);
      s2_w[2] <= bis_pkg::WGT_W'(um) * bis_pkg::WGT_W'(v);
      s2_w[3] <= bis_pkg::WGT_W'(u) * bis_pkg::WGT_W'(v);
      s2_dc   <= s1_dc;
      s2_dr   <= s1_dr;
    end
  end

  // Route banks back to neighbor positions
  logic [bis_pkg::PIX_W-1:0] nbr [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nbr[k] = bank_rdata[{s2_ty0 ^ 1'((k >> 1) & 1), s2_tx0 ^ 1'(k & 1)}];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: weight x channel products
  // ---------------------------------------------------------------------------
  logic                       s3_valid;
  logic [bis_pkg::PROD_W-1:0] s3_prod [bis_pkg::NUM_CH][4];
  logic [bis_pkg::DST_W-1:0]  s3_dc;
  logic [bis_pkg::DST_W-1:0]  s3_dr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < bis_pkg::NUM_CH; c++) begin
        for (int k = 0; k < 4; k++) begin
          s3_prod[c][k] <= bis_pkg::PROD_W'(s2_w[k])
                         * bis_pkg::PROD_W'(nbr[k][c*bis_pkg::CH_W +: bis_pkg::CH_W]);
        end
      end
      s3_dc <= s2_dc;
      s3_dr <= s2_dr;
    end
  end

  // Sum, round half up, saturate
  logic [bis_pkg::SUM_W-1:0] chan_sum [bis_pkg::NUM_CH];
  logic [bis_pkg::RES_W-1:0] chan_int [bis_pkg::NUM_CH];
  bis_pkg::chan_t            chan_res [bis_pkg::NUM_CH];

  always_comb begin
    for (int c = 0; c < bis_pkg::NUM_CH; c++) begin
      chan_sum[c] = bis_pkg::SUM_W'(s3_prod[c][0]) + bis_pkg::SUM_W'(s3_prod[c][1])
                  + bis_pkg::SUM_W'(s3_prod[c][2]) + bis_pkg::SUM_W'(s3_prod[c][3])
                  + bis_pkg::SUM_W'(1 << (2 * bis_pkg::WEIGHT_FRAC_BITS - 1));
      chan_int[c] = chan_sum[c][bis_pkg::SUM_W-1:2*bis_pkg::WEIGHT_FRAC_BITS];
      chan_res[c] = (chan_int[c] > bis_pkg::RES_W'(255)) ? bis_pkg::CH_W'(255)
                                                         : chan_int[c][bis_pkg::CH_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  bis_pkg::chan_t            out_ch [bis_pkg::NUM_CH];
  logic [bis_pkg::DST_W-1:0] out_col;
  logic [bis_pkg::DST_W-1:0] out_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < bis_pkg::NUM_CH; c++) begin
        out_ch[c] <= chan_res[c];
      end
      out_col <= s3_dc;
      out_row <= s3_dr;
    end
  end

  // channel 2 is red, channel 0 is blue
  assign m_axis_tdata = {out_row, out_col, out_ch[0], out_ch[1], out_ch[2]};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a stalled pipe keeps the query position it holds
  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_posx) && $stable(s1_posy)))
    else $error("stage 1 changed while stalled");

  // the clamped base never passes the limit, so base + 1 stays inside the frame
  a_base_in_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_mode) |-> ((tx <= x_lim) && (ty <= y_lim)))
    else $error("base column or row beyond limit");

  // a finished query reaches the output register on the next advance
  a_s3_to_out: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid) |=> m_axis_tvalid)
    else $error("query lost between sum stage and output");

  // pixel writes never make an output beat
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && !s1_mode) |=> !s2_valid)
    else $error("pixel write entered the blend pipe");

endmodule

>>> verif/tb_top.sv
module tb_top;

  // Beat kinds carried on s_axis_tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Register indexes that decode to nothing; writes there must not disturb state
  localparam logic [bis_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int CLK_HALF      = 6;
  localparam int DRAIN_CYCLES  = 8;    // pipeline is 4 deep
  localparam int PHASE_ITEMS   = 40;
  localparam int LIMIT_CYCLES  = 400000;

  // Input beat layout, lowest field last (packed structs fill from the MSB)
  typedef struct packed {
    logic [bis_pkg::DST_W-1:0] dst_row;
    logic [bis_pkg::DST_W-1:0] dst_col;
    bis_pkg::chan_t            blue;
    bis_pkg::chan_t            green;
    bis_pkg::chan_t            red;
    logic [7:0]                src_row;
    logic [7:0]                src_col;
  } beat_in_t;

  // Output beat layout: out_red sits in the lowest byte
  typedef struct packed {
    logic [bis_pkg::DST_W-1:0] row;
    logic [bis_pkg::DST_W-1:0] col;
    bis_pkg::chan_t            blue;
    bis_pkg::chan_t            green;
    bis_pkg::chan_t            red;
  } px_result_t;

  typedef enum logic [1:0] {ROW_PIX, ROW_QRY, ROW_REG} row_kind_t;

  // Directed row: PIX writes rgb at (a,b); QRY asks for (a,b); REG writes data to index a.
  // A QRY row with typed set carries its answer in want, otherwise the predictor decides.
  typedef struct packed {
    row_kind_t   kind;
    logic [11:0] a;
    logic [11:0] b;
    logic [23:0] data;
    logic        typed;
    logic [23:0] want;
  } dir_row_t;

  typedef struct packed {
    logic [23:0] width;
    logic [23:0] height;
    logic [23:0] xstep;
    logic [23:0] ystep;
  } phase_cfg_t;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    // corner blocks at both ends of the store, channel extremes
    '{ROW_PIX, 12'd0,   12'd0,   24'hFF0000, 1'b0, 24'h0},
    '{ROW_PIX, 12'd1,   12'd0,   24'h00FF00, 1'b0, 24'h0},
    '{ROW_PIX, 12'd0,   12'd1,   24'h0000FF, 1'b0, 24'h0},
    '{ROW_PIX, 12'd1,   12'd1,   24'hFFFFFF, 1'b0, 24'h0},
    '{ROW_PIX, 12'd254, 12'd254, 24'h123456, 1'b0, 24'h0},
    '{ROW_PIX, 12'd255, 12'd254, 24'hABCDEF, 1'b0, 24'h0},
    '{ROW_PIX, 12'd254, 12'd255, 24'h010203, 1'b0, 24'h0},
    '{ROW_PIX, 12'd255, 12'd255, 24'hFEDCBA, 1'b0, 24'h0},
    // origin with zero weights, then far corner clamped on both axes
    '{ROW_QRY, 12'd0,    12'd0,    24'h0, 1'b1, 24'hFF0000},
    '{ROW_QRY, 12'd4095, 12'd4095, 24'h0, 1'b1, 24'h123456},
    // half step: exact midpoint rounds up
    '{ROW_REG, 12'(bis_pkg::REG_X_STEP), 12'd0, 24'h008000, 1'b0, 24'h0},
    '{ROW_QRY, 12'd1,    12'd0,    24'h0, 1'b1, 24'h808000},
    // largest step: base clamps, fraction weight survives
    '{ROW_REG, 12'(bis_pkg::REG_X_STEP), 12'd0, 24'hFFFFFF, 1'b0, 24'h0},
    '{ROW_QRY, 12'd4095, 12'd4095, 24'h0, 1'b0, 24'h0},
    // zero step maps everything onto the origin
    '{ROW_REG, 12'(bis_pkg::REG_X_STEP), 12'd0, 24'h000000, 1'b0, 24'h0},
    '{ROW_REG, 12'(bis_pkg::REG_Y_STEP), 12'd0, 24'h000000, 1'b0, 24'h0},
    '{ROW_QRY, 12'd4095, 12'd4095, 24'h0, 1'b1, 24'hFF0000},
    // sizes below two act as two
    '{ROW_REG, 12'(bis_pkg::REG_SRC_WIDTH),  12'd0, 24'h000000, 1'b0, 24'h0},
    '{ROW_REG, 12'(bis_pkg::REG_SRC_HEIGHT), 12'd0, 24'h000001, 1'b0, 24'h0},
    '{ROW_REG, 12'(bis_pkg::REG_X_STEP),     12'd0, 24'h010000, 1'b0, 24'h0},
    '{ROW_REG, 12'(bis_pkg::REG_Y_STEP),     12'd0, 24'h010000, 1'b0, 24'h0},
    '{ROW_QRY, 12'd4095, 12'd4095, 24'h0, 1'b1, 24'hFF0000},
    // sizes above the store act as the store size
    '{ROW_REG, 12'(bis_pkg::REG_SRC_WIDTH),  12'd0, 24'h0001FF, 1'b0, 24'h0},
    '{ROW_REG, 12'(bis_pkg::REG_SRC_HEIGHT), 12'd0, 24'h00012C, 1'b0, 24'h0},
    '{ROW_QRY, 12'd4095, 12'd4095, 24'h0, 1'b1, 24'h123456},
    // undecoded indexes must leave every register alone
    '{ROW_REG, 12'(REG_SPARE_LO), 12'd0, 24'h000000, 1'b0, 24'h0},
    '{ROW_REG, 12'(REG_SPARE_HI), 12'd0, 24'hFFFFFF, 1'b0, 24'h0},
    '{ROW_QRY, 12'd4095, 12'd4095, 24'h0, 1'b0, 24'h0}
  };

  // Random phases: plain, upscale with masked width, tiny image, downscale,
  // step extremes, out-of-range sizes with a frozen row
  localparam int NUM_PHASES = 6;
  localparam phase_cfg_t PHASES [0:NUM_PHASES-1] = '{
    '{24'd256,     24'd256, 24'h010000, 24'h010000},
    '{24'h7F0025,  24'd19,  24'h004000, 24'h002AAA},
    '{24'd2,       24'd2,   24'h000800, 24'h001000},
    '{24'd256,     24'd256, 24'h020000, 24'h038000},
    '{24'd100,     24'd255, 24'hFFFFFF, 24'h000001},
    '{24'd300,     24'd0,   24'h01A3C5, 24'h000000}
  };

  logic                              clk;
  logic                              rst           = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [bis_pkg::IN_DATA_W-1:0]     s_axis_tdata  = '0;
  logic                              s_axis_tuser  = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [bis_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
  logic                              cfg_we        = 1'b0;
  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index     = '0;
  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data      = '0;

  // Predictor state: shadow registers and a shadow of the source store
  logic [bis_pkg::SIZE_W-1:0]        cur_width  = 9'd256;
  logic [bis_pkg::SIZE_W-1:0]        cur_height = 9'd256;
  logic [bis_pkg::STEP_W-1:0]        cur_xstep  = 24'h010000;
  logic [bis_pkg::STEP_W-1:0]        cur_ystep  = 24'h010000;
  logic [bis_pkg::PIX_W-1:0]         frame_mem [0:65535];
  bit                                frame_set [0:65535];

  px_result_t             pending_pixels [$];
  int                     mismatches  = 0;
  int                     send_idle   = 0;   // percent of cycles the sender holds off
  int                     recv_idle   = 0;   // percent of cycles the receiver holds off
  int                     hold_cycles = 0;   // long receiver stall, counted down below

  bilinear_image_scaler_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("bilinear_image_scaler_unit test failed");
    $finish;
  end

  function automatic logic [bis_pkg::SIZE_W-1:0] eff_size(
      input logic [bis_pkg::SIZE_W-1:0] size,
      input logic [bis_pkg::SIZE_W-1:0] maxv);
    if (size < 9'd2) return 9'd2;
    if (size > maxv) return maxv;
    return size;
  endfunction

  // Split coord * ratio into a clamped base index and an 8-bit weight
  function automatic void locate_src(input logic [bis_pkg::DST_W-1:0] coord,
                                     input logic [bis_pkg::STEP_W-1:0] ratio,
                                     input logic [bis_pkg::SIZE_W-1:0] size,
                                     input logic [bis_pkg::SIZE_W-1:0] maxv,
                                     output logic [7:0] base, output logic [7:0] wt);
    logic [35:0]                pos;
    logic [bis_pkg::SIZE_W-1:0] top;
    pos  = 36'(coord) * 36'(ratio);
    top  = eff_size(size, maxv) - 9'd2;
    wt   = pos[bis_pkg::STEP_FRAC_BITS-1 -: bis_pkg::WEIGHT_FRAC_BITS];
    base = (pos[35:bis_pkg::STEP_FRAC_BITS] >= 20'(top)) ? top[7:0] : pos[23:16];
  endfunction

  // One channel: weighted sum of the four neighbors, round half up
  function automatic bis_pkg::chan_t mix(input bis_pkg::chan_t a, input bis_pkg::chan_t b,
                                         input bis_pkg::chan_t c, input bis_pkg::chan_t d,
                                         input logic [7:0] u, input logic [7:0] v);
    int unsigned one, iu, iv, acc;
    one = 1 << bis_pkg::WEIGHT_FRAC_BITS;
    iu  = one - u;
    iv  = one - v;
    acc = iu * iv * a + u * iv * b + iu * v * c + u * v * d
        + (1 << (2 * bis_pkg::WEIGHT_FRAC_BITS - 1));
    return bis_pkg::chan_t'(acc >> (2 * bis_pkg::WEIGHT_FRAC_BITS));
  endfunction

  function automatic px_result_t interpolate(input logic [bis_pkg::DST_W-1:0] dc,
                                             input logic [bis_pkg::DST_W-1:0] dr);
    logic [7:0]                tx, ty, u, v;
    logic [bis_pkg::PIX_W-1:0] p00, p01, p10, p11;
    px_result_t                r;
    locate_src(dc, cur_xstep, cur_width,  9'(bis_pkg::MAX_SRC_WIDTH),  tx, u);
    locate_src(dr, cur_ystep, cur_height, 9'(bis_pkg::MAX_SRC_HEIGHT), ty, v);
    p00 = frame_mem[{ty, tx}];
    p01 = frame_mem[{ty, tx + 8'd1}];
    p10 = frame_mem[{ty + 8'd1, tx}];
    p11 = frame_mem[{ty + 8'd1, tx + 8'd1}];
    r.red   = mix(p00[23:16], p01[23:16], p10[23:16], p11[23:16], u, v);
    r.green = mix(p00[15:8],  p01[15:8],  p10[15:8],  p11[15:8],  u, v);
    r.blue  = mix(p00[7:0],   p01[7:0],   p10[7:0],   p11[7:0],   u, v);
    r.col   = dc;
    r.row   = dr;
    return r;
  endfunction

  // Largest destination coordinate that still lands inside the image
  function automatic int reach(input logic [bis_pkg::STEP_W-1:0] ratio,
                               input logic [bis_pkg::SIZE_W-1:0] size,
                               input logic [bis_pkg::SIZE_W-1:0] maxv);
    int r;
    if (ratio == '0) return 4095;
    r = (int'(eff_size(size, maxv)) << bis_pkg::STEP_FRAC_BITS) / int'(ratio);
    return (r > 4095) ? 4095 : r;
  endfunction

  // Offer one beat, hold it until taken, then advance the predictor.
  // tvalid stays high into the next beat unless the sender decides to idle.
  task automatic send_beat(input logic mode, input beat_in_t b, input logic typed,
                           input logic [bis_pkg::PIX_W-1:0] want);
    px_result_t res;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    if (mode == MODE_WRITE) begin
      frame_mem[{b.src_row, b.src_col}] = {b.red, b.green, b.blue};
      frame_set[{b.src_row, b.src_col}] = 1'b1;
    end else begin
      res = interpolate(b.dst_col, b.dst_row);
      if (typed) {res.red, res.green, res.blue} = want;
      pending_pixels.push_back(res);
    end
  endtask

  task automatic put_pixel(input logic [7:0] col, input logic [7:0] row);
    beat_in_t b;
    b = beat_in_t'({$urandom(), $urandom()});
    b.src_col = col;
    b.src_row = row;
    send_beat(MODE_WRITE, b, 1'b0, '0);
  endtask

  // Drop tvalid, wait for every outstanding pixel, then let the pipe run dry
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bis_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [bis_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bis_pkg::REG_SRC_WIDTH:  cur_width  = val[bis_pkg::SIZE_W-1:0];
      bis_pkg::REG_SRC_HEIGHT: cur_height = val[bis_pkg::SIZE_W-1:0];
      bis_pkg::REG_X_STEP:     cur_xstep  = val[bis_pkg::STEP_W-1:0];
      bis_pkg::REG_Y_STEP:     cur_ystep  = val[bis_pkg::STEP_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Quarter of the items are stray pixel writes anywhere in the store; the rest
  // are queries, mostly inside the image, whose four neighbors get written first
  // if they were never stored.
  task automatic random_item();
    beat_in_t     b;
    logic [11:0]  dc, dr;
    logic [7:0]   tx, ty, u, v;
    int           k;
    b = beat_in_t'({$urandom(), $urandom()});
    if ($urandom_range(99) < 25) begin
      send_beat(MODE_WRITE, b, 1'b0, '0);
    end else begin
      if ($urandom_range(99) < 70) begin
        dc = 12'($urandom_range(reach(cur_xstep, cur_width,  9'(bis_pkg::MAX_SRC_WIDTH)), 0));
        dr = 12'($urandom_range(reach(cur_ystep, cur_height, 9'(bis_pkg::MAX_SRC_HEIGHT)), 0));
      end else begin
        dc = 12'($urandom);
        dr = 12'($urandom);
      end
      locate_src(dc, cur_xstep, cur_width,  9'(bis_pkg::MAX_SRC_WIDTH),  tx, u);
      locate_src(dr, cur_ystep, cur_height, 9'(bis_pkg::MAX_SRC_HEIGHT), ty, v);
      for (k = 0; k < 4; k++) begin
        if (!frame_set[{ty + 8'(k >> 1), tx + 8'(k & 1)}])
          put_pixel(tx + 8'(k & 1), ty + 8'(k >> 1));
      end
      b.dst_col = dc;
      b.dst_row = dr;
      send_beat(MODE_QUERY, b, 1'b0, '0);
    end
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Compare every output beat against the oldest predicted pixel
  always @(posedge clk) begin : result_check
    px_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = px_result_t'(m_axis_tdata);
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: output beat with nothing expected: %h", $time, m_axis_tdata);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.col !== want.col || got.row !== want.row) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: pixel mismatch: expected (%0d,%0d) rgb %h %h %h, ",
                      "got (%0d,%0d) rgb %h %h %h"},
                     $time, want.col, want.row, want.red, want.green, want.blue,
                     got.col, got.row, got.red, got.green, got.blue);
        end
      end
    end
  end

  // Main sequence: reset, directed table, then the random phases
  initial begin : stimulus
    int       i, p;
    dir_row_t row;
    beat_in_t b;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 9;
    recv_idle = 85;
    for (i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      b   = beat_in_t'({$urandom(), $urandom()});
      case (row.kind)
        ROW_PIX: begin
          b.src_col = row.a[7:0];
          b.src_row = row.b[7:0];
          {b.red, b.green, b.blue} = row.data;
          send_beat(MODE_WRITE, b, 1'b0, '0);
        end
        ROW_QRY: begin
          b.dst_col = row.a;
          b.dst_row = row.b;
          send_beat(MODE_QUERY, b, row.typed, row.want);
        end
        default: begin
          wait_idle();
          write_reg(row.a[bis_pkg::CFG_IDX_W-1:0], row.data);
        end
      endcase
    end

    // Idling: sender light / receiver heavy, then swapped, then none at all
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      send_idle = (p < 2) ? 9 : (p < 4) ? 85 : 0;
      recv_idle = (p < 2) ? 85 : (p < 4) ? 9 : 0;
      write_reg(bis_pkg::REG_SRC_WIDTH,  PHASES[p].width);
      write_reg(bis_pkg::REG_SRC_HEIGHT, PHASES[p].height);
      write_reg(bis_pkg::REG_X_STEP,     PHASES[p].xstep);
      write_reg(bis_pkg::REG_Y_STEP,     PHASES[p].ystep);
      // Stall the output long enough for the block to back up into its input
      if (p == 4) hold_cycles = 150;
      repeat (PHASE_ITEMS) random_item();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("bilinear_image_scaler_unit test passed");
    end else begin
      $display("bilinear_image_scaler_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bis_pkg.sv
rtl/core/bilinear_image_scaler_unit.sv
verif/tb_top.sv
